### rtl/core/triangle_slice_line_core_macros.svh
// assertion macros for the triangle slice line core
`ifndef TRIANGLE_SLICE_LINE_CORE_MACROS_SVH
`define TRIANGLE_SLICE_LINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TSLC_ASSERT_IMP(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tslc assertion failed");
`define TSLC_ASSERT_NXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tslc assertion failed");
`else
`define TSLC_ASSERT_IMP(name, pre, post)
`define TSLC_ASSERT_NXT(name, pre, post)
`endif
`endif

### rtl/core/tsl_pkg.sv
// constants, types and helpers of the triangle slice line core
`default_nettype none
package tsl_pkg;
   localparam int NORM_SHIFT = 30;
   localparam int TOL_W = 16;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;
   localparam logic [0:0] REG_TOLERANCE = 1'b0;
   // square root: stages and iterations per stage (32 iterations total)
   localparam int SQS = 8;
   localparam int SQK = 4;
   // normal divider: stages and quotient bits per stage (32 bits total)
   localparam int DVS = 8;
   localparam int DVK = 4;
   // pivot divider quotient bits per stage
   localparam int QK = 4;

   typedef enum logic [1:0] {PIV_NONE, PIV_X, PIV_Y} pivot_type;

   function automatic logic [6:0] msb64(input logic [63:0] x);
      logic [6:0] r;
      r = 7'd0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) r = 7'(i);
      end
      return r;
   endfunction
endpackage
`default_nettype wire

### rtl/core/triangle_slice_line_core.sv
// triangle slice line core: plane of one triangle cut by a horizontal slice
//
//  channel  ports   direction  content
//  req      req_*   in         vertices a, b, c and slice height, one triangle per item
//  rsp      rsp_*   out        hit flag, line point and line direction
//  csr      csr_*   in/out     tolerance register at byte address 0
//
// one item per cycle in and out while the skid register is empty; the pipe holds
// the 32-step square root, the 32-bit normal divider and the pivot divider
// of COORD_WIDTH + 2 quotient bits, each worked four steps per stage
// synchronous reset clears the valid bits and sets the tolerance to 1
// all stages advance together; a skid register behind the output register
// holds one more result while a result waits, and the pipe stalls while it is full
`default_nettype none
`include "triangle_slice_line_core_macros.svh"
module triangle_slice_line_core #(
   parameter int COORD_WIDTH = 32,
   localparam int IN_W = ((10 * COORD_WIDTH + 7) / 8) * 8,
   localparam int OUT_W = ((3 * COORD_WIDTH + 64 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, slice_z
   input  logic [IN_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // line_x, line_y, line_z, dir_x, dir_y
   output logic [OUT_W-1:0] rsp_tdata,
   // hit
   output logic [0:0]       rsp_tuser,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int CW = COORD_WIDTH;
   localparam int EW = CW + 1;
   localparam int PW = CW + 32;
   localparam int QB = CW + 2;
   localparam int QS = (QB + tsl_pkg::QK - 1) / tsl_pkg::QK;
   localparam int VW = CW + 4;
   localparam int SQS = tsl_pkg::SQS;
   localparam int DVS = tsl_pkg::DVS;

   localparam int ST_IN = 0;
   localparam int ST_MAG = 1;
   localparam int ST_ES = 2;
   localparam int ST_PR = 3;
   localparam int ST_CR = 4;
   localparam int ST_CM = 5;
   localparam int ST_CN = 6;
   localparam int ST_SQ = 7;
   localparam int ST_SUM = 8;
   localparam int ST_RT0 = 9;
   localparam int ST_DS = ST_RT0 + SQS;
   localparam int ST_N = ST_DS + DVS + 1;
   localparam int ST_PV = ST_N + 1;
   localparam int ST_MUL = ST_PV + 1;
   localparam int ST_ADD = ST_MUL + 1;
   localparam int ST_OV = ST_ADD + 1;
   localparam int ST_RND = ST_OV + QS + 1;
   localparam int NST = ST_RND + 1;

   typedef struct packed {
      logic signed [CW-1:0] ax;
      logic signed [CW-1:0] ay;
      logic signed [CW-1:0] az;
      logic signed [CW-1:0] sz;
      logic signed [EW-1:0] dz;
   } side_type;

   typedef struct packed {
      logic signed [31:0]  dx;
      logic signed [31:0]  dy;
      tsl_pkg::pivot_type mode;
   } late_type;

   typedef struct packed {
      logic                 hit;
      logic signed [31:0]   dy;
      logic signed [31:0]   dx;
      logic signed [CW-1:0] lz;
      logic signed [CW-1:0] ly;
      logic signed [CW-1:0] lx;
   } out_type;

   // configuration
   logic [tsl_pkg::TOL_W-1:0] tol_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2:2] == tsl_pkg::REG_TOLERANCE) ? 32'(tol_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tsl_pkg::TOL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2:2] == tsl_pkg::REG_TOLERANCE) begin
         tol_ff <= csr_pwdata[tsl_pkg::TOL_W-1:0];
      end
   end

   // pipeline registers
   logic [NST-1:0]             v_ff;
   logic                       en;
   side_type                   side_ff [ST_IN:ST_RND];
   logic                       hit_ff [ST_MAG:ST_RND];
   logic signed [EW-1:0]       e_ff [6];
   logic signed [EW-1:0]       zd_ff [3];
   logic [EW-1:0]              em_ff [6];
   logic                       eneg_ff [6];
   logic signed [30:0]         es_ff [6];
   logic signed [61:0]         pr_ff [6];
   logic signed [62:0]         cr_ff [3];
   logic [61:0]                cm_ff [3];
   logic [2:0]                 cneg_ff [ST_CM:ST_N-1];
   logic                       czero_ff [ST_CM:ST_N-1];
   logic [30:0]                cn_ff [ST_CN:ST_DS-1][3];
   logic [61:0]                sqv_ff [3];
   logic [63:0]                sum_ff;
   logic [33:0]                rt_rem_ff [SQS];
   logic [31:0]                rt_root_ff [SQS];
   logic [63:0]                rt_src_ff [SQS];
   logic [31:0]                dv_rem_ff [DVS+1][3];
   logic [31:0]                dv_low_ff [DVS+1][3];
   logic [31:0]                dv_q_ff [DVS+1][3];
   logic [31:0]                dv_den_ff [DVS];
   logic signed [31:0]         n_ff [3];
   late_type                   lt_ff [ST_PV:ST_RND];
   logic signed [31:0]         piv_ff;
   logic signed [31:0]         nz_ff;
   logic [62:0]                p0_ff;
   logic [62:0]                p1_ff;
   logic                       neg_ff [ST_MUL:ST_RND];
   logic [30:0]                den_ff [ST_MUL:ST_RND-1];
   logic [PW-1:0]              pp_ff;
   logic                       ovf_ff [ST_OV:ST_RND-1];
   logic [30:0]                qr_rem_ff [QS+1];
   logic [QB-1:0]              qr_low_ff [QS+1];
   logic [QB-1:0]              qr_q_ff [QS+1];
   logic [QB:0]                qrnd_ff;
   logic                       sat_ff;

   // next values
   side_type                   side_in;
   logic signed [EW-1:0]       e_in [6];
   logic signed [EW-1:0]       zd_in [3];
   logic [EW-1:0]              em_in [6];
   logic                       eneg_in [6];
   logic                       hit_in;
   logic signed [30:0]         es_in [6];
   logic signed [61:0]         pr_in [6];
   logic signed [62:0]         cr_in [3];
   logic [61:0]                cm_in [3];
   logic [2:0]                 cneg_in;
   logic                       czero_in;
   logic [30:0]                cn_in [3];
   logic [61:0]                sqv_in [3];
   logic [63:0]                sum_in;
   logic [33:0]                rt_rem_in [SQS];
   logic [31:0]                rt_root_in [SQS];
   logic [63:0]                rt_src_in [SQS];
   logic [31:0]                dv_rem_in [DVS+1][3];
   logic [31:0]                dv_low_in [DVS+1][3];
   logic [31:0]                dv_q_in [DVS+1][3];
   logic signed [31:0]         n_in [3];
   late_type                   lt_in;
   logic signed [31:0]         piv_in;
   logic [62:0]                p0_in;
   logic [62:0]                p1_in;
   logic                       neg_in;
   logic [30:0]                den_in;
   logic [PW-1:0]              pp_in;
   logic                       ovf_in;
   logic [30:0]                qr_rem_in [QS+1];
   logic [QB-1:0]              qr_low_in [QS+1];
   logic [QB-1:0]              qr_q_in [QS+1];
   logic [QB:0]                qrnd_in;
   logic                       sat_in;
   out_type                    fin;

   // input unpack, edges and z offsets
   always_comb begin
      logic signed [CW-1:0] fld [10];
      for (int k = 0; k < 10; k++) begin
         fld[k] = $signed(req_tdata[k*CW +: CW]);
      end
      for (int i = 0; i < 3; i++) begin
         e_in[i] = EW'(fld[3+i]) - EW'(fld[i]);
         e_in[i+3] = EW'(fld[6+i]) - EW'(fld[i]);
         zd_in[i] = EW'(fld[3*i+2]) - EW'(fld[9]);
      end
      side_in.ax = fld[0];
      side_in.ay = fld[1];
      side_in.az = fld[2];
      side_in.sz = fld[9];
      side_in.dz = zd_in[0];
   end

   // edge magnitudes and z span test
   always_comb begin
      logic signed [EW-1:0] zmin, zmax;
      logic signed [EW:0] tolw;
      for (int i = 0; i < 6; i++) begin
         eneg_in[i] = e_ff[i][EW-1];
         em_in[i] = eneg_in[i] ? EW'(-e_ff[i]) : EW'(e_ff[i]);
      end
      zmin = zd_ff[0];
      zmax = zd_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (zd_ff[i] < zmin) zmin = zd_ff[i];
         if (zd_ff[i] > zmax) zmax = zd_ff[i];
      end
      tolw = (EW+1)'($signed({1'b0, tol_ff}));
      hit_in = ((EW+1)'(zmin) <= tolw) && (tolw <= (EW+1)'(zmax));
   end

   // common shift so every edge magnitude is below 2^30
   always_comb begin
      logic [EW-1:0] orr;
      logic [6:0] p, sh;
      logic [63:0] mag;
      orr = '0;
      for (int i = 0; i < 6; i++) orr = orr | em_ff[i];
      p = tsl_pkg::msb64(64'(orr));
      sh = (p >= 7'd30) ? 7'(p - 7'd29) : 7'd0;
      for (int i = 0; i < 6; i++) begin
         mag = 64'(em_ff[i]) >> sh;
         es_in[i] = eneg_ff[i] ? -$signed({1'b0, mag[29:0]}) : $signed({1'b0, mag[29:0]});
      end
   end

   // cross product
   always_comb begin
      pr_in[0] = 62'(es_ff[1]) * 62'(es_ff[5]);
      pr_in[1] = 62'(es_ff[2]) * 62'(es_ff[4]);
      pr_in[2] = 62'(es_ff[2]) * 62'(es_ff[3]);
      pr_in[3] = 62'(es_ff[0]) * 62'(es_ff[5]);
      pr_in[4] = 62'(es_ff[0]) * 62'(es_ff[4]);
      pr_in[5] = 62'(es_ff[1]) * 62'(es_ff[3]);
      for (int i = 0; i < 3; i++) begin
         cr_in[i] = 63'(pr_ff[2*i]) - 63'(pr_ff[2*i+1]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cneg_in[i] = cr_ff[i][62];
         cm_in[i] = cneg_in[i] ? 62'(-cr_ff[i]) : 62'(cr_ff[i]);
      end
      czero_in = (cr_ff[0] == '0) && (cr_ff[1] == '0) && (cr_ff[2] == '0);
   end

   // bring the largest magnitude into [2^30, 2^31)
   always_comb begin
      logic [61:0] orr, t;
      logic [6:0] p;
      orr = cm_ff[0] | cm_ff[1] | cm_ff[2];
      p = tsl_pkg::msb64(64'(orr));
      for (int i = 0; i < 3; i++) begin
         if (p > 7'd30) t = cm_ff[i] >> (p - 7'd30);
         else t = cm_ff[i] << (7'd30 - p);
         cn_in[i] = t[30:0];
         sqv_in[i] = 62'(cn_ff[ST_CN][i]) * 62'(cn_ff[ST_CN][i]);
      end
      sum_in = 64'(sqv_ff[0]) + 64'(sqv_ff[1]) + 64'(sqv_ff[2]);
   end

   // square root, two radicand bits per step
   always_comb begin
      logic [35:0] nx, tr;
      logic [33:0] r;
      logic [31:0] rt;
      logic [63:0] s;
      for (int j = 0; j < SQS; j++) begin
         if (j == 0) begin
            r = '0;
            rt = '0;
            s = sum_ff;
         end else begin
            r = rt_rem_ff[j-1];
            rt = rt_root_ff[j-1];
            s = rt_src_ff[j-1];
         end
         for (int k = 0; k < tsl_pkg::SQK; k++) begin
            nx = {r, s[63:62]};
            s = {s[61:0], 2'b00};
            tr = {2'b00, rt, 2'b01};
            if (nx >= tr) begin
               r = 34'(nx - tr);
               rt = {rt[30:0], 1'b1};
            end else begin
               r = nx[33:0];
               rt = {rt[30:0], 1'b0};
            end
         end
         rt_rem_in[j] = r;
         rt_root_in[j] = rt;
         rt_src_in[j] = s;
      end
   end

   // normal divider: round(cm * 2^30 / len)
   always_comb begin
      logic [61:0] num;
      logic [32:0] t;
      logic [31:0] r, lo, q, len;
      len = rt_root_ff[SQS-1];
      for (int i = 0; i < 3; i++) begin
         num = (62'(cn_ff[ST_DS-1][i]) << tsl_pkg::NORM_SHIFT) + 62'(len >> 1);
         dv_rem_in[0][i] = 32'(num[61:32]);
         dv_low_in[0][i] = num[31:0];
         dv_q_in[0][i] = '0;
      end
      for (int j = 0; j < DVS; j++) begin
         for (int i = 0; i < 3; i++) begin
            r = dv_rem_ff[j][i];
            lo = dv_low_ff[j][i];
            q = dv_q_ff[j][i];
            for (int k = 0; k < tsl_pkg::DVK; k++) begin
               t = {r, lo[31]};
               lo = {lo[30:0], 1'b0};
               if (t >= {1'b0, dv_den_ff[j]}) begin
                  r = 32'(t - {1'b0, dv_den_ff[j]});
                  q = {q[30:0], 1'b1};
               end else begin
                  r = t[31:0];
                  q = {q[30:0], 1'b0};
               end
            end
            dv_rem_in[j+1][i] = r;
            dv_low_in[j+1][i] = lo;
            dv_q_in[j+1][i] = q;
         end
      end
   end

   // signed normal and pivot choice
   always_comb begin
      logic [31:0] mnx, mny;
      for (int i = 0; i < 3; i++) begin
         if (czero_ff[ST_N-1]) n_in[i] = '0;
         else if (cneg_ff[ST_N-1][i]) n_in[i] = -$signed(dv_q_ff[DVS][i]);
         else n_in[i] = $signed(dv_q_ff[DVS][i]);
      end
      mnx = n_ff[0][31] ? 32'(-n_ff[0]) : 32'(n_ff[0]);
      mny = n_ff[1][31] ? 32'(-n_ff[1]) : 32'(n_ff[1]);
      lt_in.dx = n_ff[1];
      lt_in.dy = -n_ff[0];
      if (mnx > 32'(tol_ff)) lt_in.mode = tsl_pkg::PIV_X;
      else if (mny > 32'(tol_ff)) lt_in.mode = tsl_pkg::PIV_Y;
      else lt_in.mode = tsl_pkg::PIV_NONE;
      piv_in = (lt_in.mode == tsl_pkg::PIV_X) ? n_ff[0] : n_ff[1];
   end

   // nz * dz in two partial products, then the overflow check
   always_comb begin
      logic [30:0] nm;
      logic [EW-1:0] dm;
      logic [63:0] dm64;
      logic signed [EW-1:0] dz;
      logic [29:0] top;
      dz = side_ff[ST_PV].dz;
      nm = nz_ff[31] ? 31'(-nz_ff) : 31'(nz_ff);
      dm = dz[EW-1] ? EW'(-dz) : EW'(dz);
      dm64 = 64'(dm);
      p0_in = 63'(nm) * 63'(dm64[31:0]);
      p1_in = 63'(nm) * 63'(dm64[63:32]);
      neg_in = nz_ff[31] ^ dz[EW-1] ^ piv_ff[31];
      den_in = piv_ff[31] ? 31'(-piv_ff) : 31'(piv_ff);
      pp_in = PW'(p0_ff) + PW'({p1_ff, 32'd0});
      top = pp_ff[PW-1:QB];
      ovf_in = {1'b0, top} >= den_ff[ST_ADD];
      qr_rem_in[0] = {1'b0, top};
      qr_low_in[0] = pp_ff[QB-1:0];
      qr_q_in[0] = '0;
   end

   // pivot divider
   always_comb begin
      logic [31:0] t;
      logic [30:0] r;
      logic [QB-1:0] lo, q;
      for (int j = 0; j < QS; j++) begin
         r = qr_rem_ff[j];
         lo = qr_low_ff[j];
         q = qr_q_ff[j];
         for (int k = 0; k < tsl_pkg::QK; k++) begin
            if (j * tsl_pkg::QK + k < QB) begin
               t = {r, lo[QB-1]};
               lo = lo << 1;
               if (t >= {1'b0, den_ff[ST_OV+j]}) begin
                  r = 31'(t - {1'b0, den_ff[ST_OV+j]});
                  q = {q[QB-2:0], 1'b1};
               end else begin
                  r = t[30:0];
                  q = {q[QB-2:0], 1'b0};
               end
            end
         end
         qr_rem_in[j+1] = r;
         qr_low_in[j+1] = lo;
         qr_q_in[j+1] = q;
      end
   end

   // rounding, halves away from zero, and saturation flag
   always_comb begin
      logic [30:0] r, d;
      r = qr_rem_ff[QS];
      d = den_ff[ST_RND-1];
      qrnd_in = (QB+1)'(qr_q_ff[QS]) + (QB+1)'(r >= 31'(d - r));
      sat_in = ovf_ff[ST_RND-1] || (qrnd_in > (QB+1)'({1'b1, {CW{1'b0}}}));
   end

   // final point
   always_comb begin
      logic signed [CW-1:0] cmax, cmin, base, sv;
      logic signed [VW-1:0] bs, qs, v;
      side_type sd;
      late_type lt;
      sd = side_ff[ST_RND];
      lt = lt_ff[ST_RND];
      cmax = {1'b0, {(CW-1){1'b1}}};
      cmin = {1'b1, {(CW-1){1'b0}}};
      base = (lt.mode == tsl_pkg::PIV_X) ? sd.ax : sd.ay;
      bs = VW'(base);
      qs = $signed({1'b0, qrnd_ff});
      v = neg_ff[ST_RND] ? bs - qs : bs + qs;
      if (sat_ff) sv = neg_ff[ST_RND] ? cmin : cmax;
      else if (v > VW'(cmax)) sv = cmax;
      else if (v < VW'(cmin)) sv = cmin;
      else sv = CW'(v);
      fin = '0;
      if (hit_ff[ST_RND]) begin
         fin.hit = 1'b1;
         fin.dx = lt.dx;
         fin.dy = lt.dy;
         case (lt.mode)
            tsl_pkg::PIV_X: begin
               fin.lx = sv;
               fin.ly = sd.ay;
               fin.lz = sd.sz;
            end
            tsl_pkg::PIV_Y: begin
               fin.lx = sd.ax;
               fin.ly = sv;
               fin.lz = sd.sz;
            end
            default: begin
               fin.lx = sd.ax;
               fin.ly = sd.ay;
               fin.lz = sd.az;
            end
         endcase
      end
   end

   // output register and skid
   out_type out_ff, skid_ff;
   logic    out_v_ff, skid_v_ff;

   assign en = !skid_v_ff;
   assign req_tready = en;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = OUT_W'({out_ff.dy, out_ff.dx, out_ff.lz, out_ff.ly, out_ff.lx});
   assign rsp_tuser = out_ff.hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (en) v_ff <= {v_ff[NST-2:0], req_tvalid};
         if (skid_v_ff) begin
            if (rsp_tready) begin
               out_ff <= skid_ff;
               skid_v_ff <= 1'b0;
            end
         end else if (v_ff[ST_RND]) begin
            if (!out_v_ff || rsp_tready) begin
               out_ff <= fin;
               out_v_ff <= 1'b1;
            end else begin
               skid_ff <= fin;
               skid_v_ff <= 1'b1;
            end
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[ST_IN] <= side_in;
         for (int k = ST_IN + 1; k <= ST_RND; k++) side_ff[k] <= side_ff[k-1];
         hit_ff[ST_MAG] <= hit_in;
         for (int k = ST_MAG + 1; k <= ST_RND; k++) hit_ff[k] <= hit_ff[k-1];
         e_ff <= e_in;
         zd_ff <= zd_in;
         em_ff <= em_in;
         eneg_ff <= eneg_in;
         es_ff <= es_in;
         pr_ff <= pr_in;
         cr_ff <= cr_in;
         cm_ff <= cm_in;
         cneg_ff[ST_CM] <= cneg_in;
         czero_ff[ST_CM] <= czero_in;
         for (int k = ST_CM + 1; k <= ST_N - 1; k++) begin
            cneg_ff[k] <= cneg_ff[k-1];
            czero_ff[k] <= czero_ff[k-1];
         end
         cn_ff[ST_CN] <= cn_in;
         for (int k = ST_CN + 1; k <= ST_DS - 1; k++) cn_ff[k] <= cn_ff[k-1];
         sqv_ff <= sqv_in;
         sum_ff <= sum_in;
         rt_rem_ff <= rt_rem_in;
         rt_root_ff <= rt_root_in;
         rt_src_ff <= rt_src_in;
         dv_rem_ff <= dv_rem_in;
         dv_low_ff <= dv_low_in;
         dv_q_ff <= dv_q_in;
         dv_den_ff[0] <= rt_root_ff[SQS-1];
         for (int k = 1; k < DVS; k++) dv_den_ff[k] <= dv_den_ff[k-1];
         n_ff <= n_in;
         lt_ff[ST_PV] <= lt_in;
         for (int k = ST_PV + 1; k <= ST_RND; k++) lt_ff[k] <= lt_ff[k-1];
         piv_ff <= piv_in;
         nz_ff <= n_ff[2];
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         neg_ff[ST_MUL] <= neg_in;
         for (int k = ST_MUL + 1; k <= ST_RND; k++) neg_ff[k] <= neg_ff[k-1];
         den_ff[ST_MUL] <= den_in;
         for (int k = ST_MUL + 1; k <= ST_RND - 1; k++) den_ff[k] <= den_ff[k-1];
         pp_ff <= pp_in;
         ovf_ff[ST_OV] <= ovf_in;
         for (int k = ST_OV + 1; k <= ST_RND - 1; k++) ovf_ff[k] <= ovf_ff[k-1];
         qr_rem_ff <= qr_rem_in;
         qr_low_ff <= qr_low_in;
         qr_q_ff <= qr_q_in;
         qrnd_ff <= qrnd_in;
         sat_ff <= sat_in;
      end
   end

   `TSLC_ASSERT_IMP(a_skid_needs_full_output, skid_v_ff, out_v_ff)
   `TSLC_ASSERT_NXT(a_stall_holds_valids, !req_tready, $stable(v_ff))
   `TSLC_ASSERT_NXT(a_accept_enters_pipe, req_tvalid && req_tready, v_ff[ST_IN])
   `TSLC_ASSERT_IMP(a_miss_is_zero, out_v_ff && !out_ff.hit, rsp_tdata == '0)
endmodule
`default_nettype wire

### sim/tb.sv
// testbench for the triangle slice line core: random and directed triangles checked against a predictor
`timescale 1ns / 1ps
module tb;

   localparam int CW = 32;
   localparam int IN_W = 320;
   localparam int OUT_W = 160;
   localparam int LATENCY = 42;
   localparam longint LIMIT = 400000;

   typedef struct packed {
      logic [31:0] dir_y;
      logic [31:0] dir_x;
      logic [31:0] line_z;
      logic [31:0] line_y;
      logic [31:0] line_x;
      logic        hit;
   } slice_line_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   slice_line_type expected_lines[$];
   longint tol_q = 1;
   int errors = 0;
   longint cycles = 0;
   bit draining = 1'b0;
   int hold_cnt = 0;

   triangle_slice_line_core #(.COORD_WIDTH(CW)) u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint unsigned mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   // unit normal of the triangle in Q2.30
   function automatic void unit_normal(input longint a[3], input longint b[3],
                                       input longint c[3], output longint n[3]);
      longint e[6], cr[3];
      longint unsigned cm[3], m, sum, len, q;
      int s;
      for (int i = 0; i < 3; i++) begin
         e[i] = b[i] - a[i];
         e[i+3] = c[i] - a[i];
      end
      m = 0;
      for (int i = 0; i < 6; i++) if (mag(e[i]) > m) m = mag(e[i]);
      s = 0;
      while ((m >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 6; i++)
         e[i] = e[i] < 0 ? -longint'(mag(e[i]) >> s) : longint'(mag(e[i]) >> s);
      cr[0] = e[1]*e[5] - e[2]*e[4];
      cr[1] = e[2]*e[3] - e[0]*e[5];
      cr[2] = e[0]*e[4] - e[1]*e[3];
      m = 0;
      for (int i = 0; i < 3; i++) begin
         cm[i] = mag(cr[i]);
         if (cm[i] > m) m = cm[i];
      end
      if (m == 0) begin
         n = '{0, 0, 0};
         return;
      end
      while (m >= (64'd1 << 31)) begin
         m >>= 1;
         for (int i = 0; i < 3; i++) cm[i] >>= 1;
      end
      while (m < (64'd1 << 30)) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) cm[i] <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += cm[i] * cm[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((cm[i] << tsl_pkg::NORM_SHIFT) + (len >> 1)) / len;
         n[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   // base + round(nz * dz / piv), saturated
   function automatic longint solve_coord(longint base, longint nz, longint dz, longint piv);
      longint hi, lo, v;
      longint unsigned nm, dm, den;
      logic [127:0] prod, quo, rem;
      bit neg;
      hi = (64'sd1 << (CW - 1)) - 1;
      lo = -hi - 1;
      nm = mag(nz);
      dm = mag(dz);
      den = mag(piv);
      neg = ((nz < 0) != (dz < 0)) != (piv < 0);
      if (den == 0 || den > 64'hFFFF_FFFF || nm > 64'hFFFF_FFFF) return base;
      prod = 128'(nm) * 128'(dm);
      quo = prod / den;
      rem = prod % den;
      if (rem >= den - rem) quo += 1;
      if (quo > (128'd1 << CW)) return neg ? lo : hi;
      v = base + (neg ? -longint'(quo[63:0]) : longint'(quo[63:0]));
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   function automatic slice_line_type predict_slice(logic [IN_W-1:0] d);
      longint a[3], b[3], c[3], n[3], z, zmin, zmax, px, py, pz;
      slice_line_type r;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(d[32*i +: 32]));
         b[i] = longint'($signed(d[32*(3+i) +: 32]));
         c[i] = longint'($signed(d[32*(6+i) +: 32]));
      end
      z = longint'($signed(d[288 +: 32]));
      zmin = a[2];
      zmax = a[2];
      if (b[2] < zmin) zmin = b[2];
      if (c[2] < zmin) zmin = c[2];
      if (b[2] > zmax) zmax = b[2];
      if (c[2] > zmax) zmax = c[2];
      r = '0;
      r.hit = (zmin - z <= tol_q) && (tol_q <= zmax - z);
      if (r.hit) begin
         unit_normal(a, b, c, n);
         r.dir_x = n[1][31:0];
         r.dir_y = 32'(-n[0]);
         px = a[0];
         py = a[1];
         pz = a[2];
         if (longint'(mag(n[0])) > tol_q) begin
            px = solve_coord(a[0], n[2], a[2] - z, n[0]);
            pz = z;
         end else if (longint'(mag(n[1])) > tol_q) begin
            py = solve_coord(a[1], n[2], a[2] - z, n[1]);
            pz = z;
         end
         r.line_x = px[31:0];
         r.line_y = py[31:0];
         r.line_z = pz[31:0];
      end
      return r;
   endfunction

   // result checker with random back pressure
   always @(posedge clock) begin
      slice_line_type got, exp_line;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tuser[0]};
            if (expected_lines.size() == 0) begin
               $display("%0t: unexpected item %h", $time, got);
               errors++;
            end else begin
               exp_line = expected_lines.pop_front();
               if (got.hit !== exp_line.hit)
                  $display("%0t: hit exp %h got %h", $time, exp_line.hit, got.hit);
               if (got.line_x !== exp_line.line_x)
                  $display("%0t: line_x exp %h got %h", $time, exp_line.line_x, got.line_x);
               if (got.line_y !== exp_line.line_y)
                  $display("%0t: line_y exp %h got %h", $time, exp_line.line_y, got.line_y);
               if (got.line_z !== exp_line.line_z)
                  $display("%0t: line_z exp %h got %h", $time, exp_line.line_z, got.line_z);
               if (got.dir_x !== exp_line.dir_x)
                  $display("%0t: dir_x exp %h got %h", $time, exp_line.dir_x, got.dir_x);
               if (got.dir_y !== exp_line.dir_y)
                  $display("%0t: dir_y exp %h got %h", $time, exp_line.dir_y, got.dir_y);
               if (got !== exp_line) errors++;
            end
         end
         if (draining) rsp_tready <= 1'b1;
         else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) == 0) begin
            // occasional long stall
            hold_cnt <= $urandom_range(10, 40);
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 9) < 2) rsp_tready <= 1'b0;
         else rsp_tready <= 1'b1;
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_triangle(logic [IN_W-1:0] d);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_lines.insert(expected_lines.size(), predict_slice(d));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [31:0] v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(tsl_pkg::REG_TOLERANCE) << 2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tol_q = v[15:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [IN_W-1:0] pack_tri(longint a[3], longint b[3], longint c[3],
                                                longint z);
      logic [IN_W-1:0] d;
      for (int i = 0; i < 3; i++) begin
         d[32*i +: 32] = a[i][31:0];
         d[32*(3+i) +: 32] = b[i][31:0];
         d[32*(6+i) +: 32] = c[i][31:0];
      end
      d[288 +: 32] = z[31:0];
      return d;
   endfunction

   function automatic longint rand_coord(int mode);
      case (mode)
         0: return longint'($signed($urandom()));
         1: return longint'($signed($urandom_range(0, 32'h00FF_FFFF))) - 64'sh80_0000;
         default: return longint'($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   // triangle straddling the slice so most items hit
   function automatic logic [IN_W-1:0] rand_hit_tri();
      longint a[3], b[3], c[3], z;
      int mode;
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
         a[i] = rand_coord(mode);
         b[i] = rand_coord(mode);
         c[i] = rand_coord(mode);
      end
      if (mode == 0) begin
         z = rand_coord(0);
      end else begin
         z = a[2];
         if (b[2] < z) z = b[2];
         z = z + longint'($urandom_range(0, 1000));
      end
      if ($urandom_range(0, 9) == 0) c = a;
      if ($urandom_range(0, 9) == 0) begin
         b[2] = a[2];
         c[2] = a[2];
         z = a[2] - tol_q;
      end
      return pack_tri(a, b, c, z);
   endfunction

   task automatic test_directed();
      longint mx, mn;
      mx = 64'sh7FFF_FFFF;
      mn = -64'sh8000_0000;
      send_triangle('0);
      send_triangle({IN_W{1'b1}});
      send_triangle(pack_tri('{mn, mn, mn}, '{mx, mx, mx}, '{mn, mx, mx}, 0));
      send_triangle(pack_tri('{mx, mn, mn}, '{mn, mx, mx}, '{0, 0, mx}, mn));
      send_triangle(pack_tri('{0, 0, 0}, '{65536, 0, 0}, '{0, 65536, 0}, 0));
      send_triangle(pack_tri('{0, 0, 0}, '{65536, 0, 65536}, '{0, 65536, 0}, 100));
      send_triangle(pack_tri('{0, 0, 0}, '{0, 65536, 65536}, '{65536, 0, 0}, 100));
      send_triangle(pack_tri('{5, 7, 0}, '{5, 7, 100}, '{5, 7, 200}, 50));
      send_triangle(pack_tri('{0, 0, 0}, '{1, 0, 65536}, '{0, 1, mx}, 3));
      send_triangle(pack_tri('{mn, 0, 0}, '{mn + 1, 0, 1}, '{mn, 1, 0}, 1));
      send_triangle(pack_tri('{0, 0, 10}, '{100, 0, 20}, '{0, 100, 30}, 9));
      send_triangle(pack_tri('{0, 0, 10}, '{100, 0, 20}, '{0, 100, 30}, 31));
      send_triangle(pack_tri('{0, 0, 10}, '{100, 0, 20}, '{0, 100, 30}, 29));
      send_triangle(pack_tri('{0, 0, 10}, '{100, 0, 20}, '{0, 100, 30}, 11));
      send_triangle(pack_tri('{mx, mx, 0}, '{mx, mx - 1, mx}, '{mx - 1, mx, mn}, 0));
      for (int i = 0; i < 6; i++) send_triangle(rand_hit_tri());
   endtask

   task automatic test_random(int n);
      logic [IN_W-1:0] d;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            for (int w = 0; w < IN_W / 32; w++) d[32*w +: 32] = $urandom();
            send_triangle(d);
         end else send_triangle(rand_hit_tri());
      end
   endtask

   task automatic test_back_to_back();
      for (int i = 0; i < 40; i++) begin
         req_tvalid <= 1'b1;
         req_tdata <= rand_hit_tri();
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         expected_lines.insert(expected_lines.size(), predict_slice(req_tdata));
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_idle();
      write_tolerance(0);
      test_random(120);
      wait_idle();
      write_tolerance(32'h0000_FFFF);
      test_directed();
      test_random(60);
      wait_idle();
      write_tolerance(32'h1234_0100);
      test_random(150);
      test_back_to_back();
      wait_idle();
      write_tolerance(32'hFFFF_0001);
      test_random(150);
      draining = 1'b1;
      wait_idle();
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
